FILE: hw/rtl/dark_channel_min_filter_defines.svh
// Assertion macros for the dark channel minimum filter.
// Expects clk and arst_n in the scope of each use.
`ifndef DARK_CHANNEL_MIN_FILTER_DEFINES_SVH
`define DARK_CHANNEL_MIN_FILTER_DEFINES_SVH

// Same-cycle implication.
`define DCMF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DCMF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/dcmf_pkg.sv
// Shared constants, types and helpers of the dark channel minimum filter.
// No dependencies.
`default_nettype none
package dcmf_pkg;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_HALF   = 7;
	localparam int RING_ROWS  = 2 * MAX_HALF + 1;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int RING_W     = $clog2(RING_ROWS);
	localparam int ADDR_W     = COL_W + RING_W;
	localparam int RAM_DEPTH  = RING_ROWS * MAX_WIDTH;
	localparam int DIM_W      = 11;
	localparam int HALF_W     = 3;
	localparam int PIX_W      = 8;
	localparam int CNT_W      = 21;
	localparam int OCNT_W     = 20;
	localparam int IDX_W      = 2;
	localparam int STEP_W     = $clog2(CNT_W);

	// row / RING_ROWS as (row * RING_RECIP) >> RING_SHIFT, exact for every DIM_W-bit row
	localparam int                RECIP_W    = 12;
	localparam int                PROD_W     = DIM_W + RECIP_W;
	localparam int                RING_SHIFT = 15;
	localparam int                RQUO_W     = PROD_W - RING_SHIFT;
	localparam logic [RECIP_W-1:0] RING_RECIP = 12'd2185;

	localparam logic [IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] CFG_HALF   = 2'd2;

	typedef enum logic {
		DIV_TROW,
		DIV_NROW
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CALC,
		ST_CHECK,
		ST_DECIDE,
		ST_DT_GO,
		ST_DT_WAIT,
		ST_DN_GO,
		ST_DN_WAIT,
		ST_BOUND,
		ST_WIN_INIT,
		ST_READ,
		ST_CMP,
		ST_EMIT,
		ST_WRITE,
		ST_COUNT
	} state_t;

	typedef struct packed {
		logic     load;
		logic     calc;
		logic     clear;
		logic     div_start;
		div_sel_t div_sel;
		logic     div_take;
		logic     bound;
		logic     win_init;
		logic     ram_re;
		logic     step;
		logic     emit;
		logic     ram_we;
		logic     count;
	} dp_cmd_t;

	typedef struct packed {
		logic phase;
		logic drain_skip;
		logic emit_due;
		logic div_done;
		logic win_last;
		logic out_free;
	} dp_stat_t;

	function automatic logic [PIX_W-1:0] min_pix(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	// ring row of an image row: row mod RING_ROWS
	function automatic logic [RING_W-1:0] ring_of(input logic [DIM_W-1:0] row);
		logic [PROD_W-1:0] prod;
		logic [RQUO_W-1:0] quo;
		logic [DIM_W-1:0]  rem;
		prod = {{RECIP_W{1'b0}}, row} * {{DIM_W{1'b0}}, RING_RECIP};
		quo  = prod[PROD_W-1:RING_SHIFT];
		rem  = row - DIM_W'(quo) * DIM_W'(RING_ROWS);
		return rem[RING_W-1:0];
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/dcmf_if.sv
// Handshake channels of the dark channel minimum filter: pixel in, result out.
// Depends on dcmf_pkg.
`default_nettype none
interface dcmf_in_if;
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [dcmf_pkg::PIX_W-1:0] red;
	logic [dcmf_pkg::PIX_W-1:0] green;
	logic [dcmf_pkg::PIX_W-1:0] blue;
	modport source (output valid, cmd, red, green, blue, input ready);
	modport sink (input valid, cmd, red, green, blue, output ready);
endinterface

interface dcmf_out_if;
	logic                      valid;
	logic                      ready;
	logic [dcmf_pkg::PIX_W-1:0] dark_value;
	logic                      frame_last;
	modport source (output valid, dark_value, frame_last, input ready);
	modport sink (input valid, dark_value, frame_last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/dcmf_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module dcmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/dcmf_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on dcmf_pkg.
`default_nettype none
module dcmf_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [dcmf_pkg::CNT_W-1:0] dividend,
	input  wire logic [dcmf_pkg::DIM_W-1:0] divisor,
	output logic                            done,
	output logic      [dcmf_pkg::CNT_W-1:0] quotient,
	output logic      [dcmf_pkg::DIM_W-1:0] remainder
);
	import dcmf_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  quo_q;
	logic [DIM_W-1:0]  rem_q;
	logic [DIM_W-1:0]  dvs_q;
	logic [DIM_W:0]    shifted;
	logic [DIM_W:0]    diff;
	logic              ge;

	always_comb begin
		shifted = {rem_q, quo_q[CNT_W-1]};
		ge      = shifted >= {1'b0, dvs_q};
		diff    = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(CNT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[CNT_W-2:0], ge};
			rem_q <= ge ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

FILE: hw/rtl/dcmf_datapath.sv
// Datapath: configuration registers, counters, window scan, line store, result register.
// Depends on dcmf_pkg, dcmf_if, dcmf_div, dcmf_ram.
`default_nettype none
module dcmf_datapath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_write,
	input  wire logic [dcmf_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [dcmf_pkg::DIM_W-1:0] cfg_data,
	input  wire dcmf_pkg::dp_cmd_t          cmd,
	output dcmf_pkg::dp_stat_t              stat,
	dcmf_in_if.sink                         pix_in,
	dcmf_out_if.source                      dark_out
);
	import dcmf_pkg::*;

	logic [DIM_W-1:0]  cfg_w_q, cfg_h_q;
	logic [HALF_W-1:0] cfg_half_q;
	logic [DIM_W-1:0]  w_c, hgt_c;
	logic [HALF_W-1:0] h_c;
	logic [DIM_W-1:0]  h_ext;

	logic              cmd_q;
	logic [PIX_W-1:0]  pix_q;
	logic [CNT_W-1:0]  total_q, lat_q;
	logic [CNT_W-1:0]  items_q;
	logic [OCNT_W-1:0] outs_q;
	logic [DIM_W-1:0]  trow_q, tcol_q, nrow_q, ncol_q;
	logic [DIM_W-1:0]  r0_q, r1_q, c0_q, c1_q;
	logic [RING_W-1:0] ring_q;
	logic [RING_W-1:0] wring;
	logic [DIM_W-1:0]  y_q, x_q;
	logic [PIX_W-1:0]  best_q;
	logic              out_valid_q;
	logic [PIX_W-1:0]  out_dark_q;
	logic              out_last_q;

	logic [CNT_W-1:0]  div_dividend, div_quo;
	logic [DIM_W-1:0]  div_divisor, div_rem;
	logic              div_done;
	logic [PIX_W-1:0]  ram_rdata, cell_v;
	logic [ADDR_W-1:0] ram_addr;
	logic              phase, use_pix, is_last_out, frame_over;
	logic [DIM_W:0]    rsum, csum;

	always_comb begin
		w_c = cfg_w_q;
		if (cfg_w_q == '0) w_c = DIM_W'(1);
		if (cfg_w_q > DIM_W'(MAX_WIDTH)) w_c = DIM_W'(MAX_WIDTH);
		hgt_c = cfg_h_q;
		if (cfg_h_q == '0) hgt_c = DIM_W'(1);
		if (cfg_h_q > DIM_W'(MAX_HEIGHT)) hgt_c = DIM_W'(MAX_HEIGHT);
		h_c = cfg_half_q;
		if (cfg_half_q > HALF_W'(MAX_HALF)) h_c = HALF_W'(MAX_HALF);
		if (DIM_W'(h_c) > w_c - DIM_W'(1)) h_c = HALF_W'(w_c - DIM_W'(1));
		if (DIM_W'(h_c) > hgt_c - DIM_W'(1)) h_c = HALF_W'(hgt_c - DIM_W'(1));
		h_ext = DIM_W'(h_c);
	end

	always_comb begin
		phase       = items_q < total_q;
		is_last_out = {1'b0, outs_q} == total_q - CNT_W'(1);
		frame_over  = ({1'b0, outs_q} >= total_q) ||
			({1'b0, items_q} >= {1'b0, total_q} + {1'b0, lat_q});
		use_pix     = phase && (y_q == trow_q) && (x_q == tcol_q);
		cell_v      = use_pix ? pix_q : ram_rdata;
		rsum        = {1'b0, nrow_q} + {1'b0, h_ext};
		csum        = {1'b0, ncol_q} + {1'b0, h_ext};
		stat.phase      = phase;
		stat.drain_skip = phase && cmd_q;
		stat.emit_due   = items_q >= lat_q;
		stat.div_done   = div_done;
		stat.win_last   = (y_q == r1_q) && (x_q == c1_q);
		stat.out_free   = !out_valid_q || dark_out.ready;
	end

	always_comb begin
		unique case (cmd.div_sel)
			DIV_TROW: begin
				div_dividend = items_q;
				div_divisor  = w_c;
			end
			DIV_NROW: begin
				div_dividend = CNT_W'(outs_q);
				div_divisor  = w_c;
			end
		endcase
		wring    = ring_of(trow_q);
		ram_addr = cmd.ram_we ? {wring, tcol_q[COL_W-1:0]} : {ring_q, x_q[COL_W-1:0]};
	end

	dcmf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	dcmf_ram #(
		.WIDTH (PIX_W),
		.DEPTH (RAM_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (cmd.ram_we),
		.re    (cmd.ram_re),
		.addr  (ram_addr),
		.wdata (pix_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q     <= DIM_W'(1024);
			cfg_h_q     <= DIM_W'(1024);
			cfg_half_q  <= HALF_W'(1);
			items_q     <= '0;
			outs_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == CFG_WIDTH) cfg_w_q <= cfg_data;
				if (cfg_index == CFG_HEIGHT) cfg_h_q <= cfg_data;
				if (cfg_index == CFG_HALF) cfg_half_q <= cfg_data[HALF_W-1:0];
			end
			if (cmd.clear && frame_over) begin
				items_q <= '0;
				outs_q  <= '0;
			end else if (cmd.count) begin
				if (stat.emit_due && is_last_out) begin
					items_q <= '0;
					outs_q  <= '0;
				end else begin
					items_q <= items_q + CNT_W'(1);
					if (stat.emit_due) outs_q <= outs_q + OCNT_W'(1);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (dark_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= pix_in.cmd;
			pix_q <= min_pix(min_pix(pix_in.red, pix_in.green), pix_in.blue);
		end
		if (cmd.calc) begin
			total_q <= CNT_W'(w_c) * CNT_W'(hgt_c);
			lat_q   <= CNT_W'(h_c) * CNT_W'(w_c) + CNT_W'(h_c);
		end
		if (cmd.div_take) begin
			unique case (cmd.div_sel)
				DIV_TROW: begin
					trow_q <= div_quo[DIM_W-1:0];
					tcol_q <= div_rem;
				end
				DIV_NROW: begin
					nrow_q <= div_quo[DIM_W-1:0];
					ncol_q <= div_rem;
				end
			endcase
		end
		if (cmd.bound) begin
			r0_q <= (nrow_q >= h_ext) ? nrow_q - h_ext : '0;
			r1_q <= (rsum < {1'b0, hgt_c}) ? rsum[DIM_W-1:0] : hgt_c - DIM_W'(1);
			c0_q <= (ncol_q >= h_ext) ? ncol_q - h_ext : '0;
			c1_q <= (csum < {1'b0, w_c}) ? csum[DIM_W-1:0] : w_c - DIM_W'(1);
		end
		if (cmd.win_init) begin
			y_q    <= r0_q;
			x_q    <= c0_q;
			ring_q <= ring_of(r0_q);
			best_q <= '1;
		end else if (cmd.step) begin
			best_q <= min_pix(best_q, cell_v);
			if (x_q == c1_q) begin
				x_q    <= c0_q;
				y_q    <= y_q + DIM_W'(1);
				ring_q <= (ring_q == RING_W'(RING_ROWS - 1)) ? '0 : ring_q + RING_W'(1);
			end else begin
				x_q <= x_q + DIM_W'(1);
			end
		end
		if (cmd.emit) begin
			out_dark_q <= best_q;
			out_last_q <= is_last_out;
		end
	end

	assign dark_out.valid      = out_valid_q;
	assign dark_out.dark_value = out_dark_q;
	assign dark_out.frame_last = out_last_q;
endmodule
`default_nettype wire

FILE: hw/rtl/dcmf_ctrl.sv
// Controller state machine that sequences one item through the datapath.
// Depends on dcmf_pkg.
`default_nettype none
module dcmf_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire dcmf_pkg::dp_stat_t stat,
	output dcmf_pkg::dp_cmd_t       cmd
);
	import dcmf_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = DIV_TROW;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.clear = 1'b1;
				state_d   = ST_DECIDE;
			end
			ST_DECIDE: begin
				priority if (stat.drain_skip) state_d = ST_IDLE;
				else if (stat.phase) state_d = ST_DT_GO;
				else if (stat.emit_due) state_d = ST_DN_GO;
				else state_d = ST_COUNT;
			end
			ST_DT_GO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DT_WAIT;
			end
			ST_DT_WAIT: begin
				if (stat.div_done) begin
					cmd.div_take = 1'b1;
					state_d      = stat.emit_due ? ST_DN_GO : ST_WRITE;
				end
			end
			ST_DN_GO: begin
				cmd.div_sel   = DIV_NROW;
				cmd.div_start = 1'b1;
				state_d       = ST_DN_WAIT;
			end
			ST_DN_WAIT: begin
				cmd.div_sel = DIV_NROW;
				if (stat.div_done) begin
					cmd.div_take = 1'b1;
					state_d      = ST_BOUND;
				end
			end
			ST_BOUND: begin
				cmd.bound = 1'b1;
				state_d   = ST_WIN_INIT;
			end
			ST_WIN_INIT: begin
				cmd.win_init = 1'b1;
				state_d      = ST_READ;
			end
			ST_READ: begin
				cmd.ram_re = 1'b1;
				state_d    = ST_CMP;
			end
			ST_CMP: begin
				cmd.step = 1'b1;
				state_d  = stat.win_last ? ST_EMIT : ST_READ;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = stat.phase ? ST_WRITE : ST_COUNT;
				end
			end
			ST_WRITE: begin
				cmd.ram_we = 1'b1;
				state_d    = ST_COUNT;
			end
			ST_COUNT: begin
				cmd.count = 1'b1;
				state_d   = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

FILE: hw/rtl/dark_channel_min_filter.sv
// Dark channel minimum filter: takes RGB pixels in raster order and returns, for each
// pixel, the minimum of R, G and B over a (2h+1)-square window clipped to the image.
// The result for pixel n leaves with item n+h*W+h; drain items (cmd = 1) flush the tail,
// and a drain item during the pixel phase is dropped. One item at a time: a pixel is taken
// and classified, its row and column are found by division on the serial divider, and it
// is written to the line store and counted. An item that produces a result adds the
// division of the output index, bounds, window setup and the result register, and a scan
// of the clipped window through the single line store port; a drain item with a result
// skips the first division and the write. A finished result waits in an output register,
// and the item stalls while that register is full and not being taken. The line store
// holds 15 rows of 1024 entries; width and height must exceed h, and configuration is to be
// written by the user only while the block is idle; the block itself does not enforce it.
`default_nettype none
`include "dark_channel_min_filter_defines.svh"
module dark_channel_min_filter (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_write,
	input  wire logic [dcmf_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [dcmf_pkg::DIM_W-1:0] cfg_data,
	dcmf_in_if.sink                         pix_in,
	dcmf_out_if.source                      dark_out
);
	import dcmf_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_ready;

	dcmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix_in.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dcmf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.pix_in    (pix_in),
		.dark_out  (dark_out)
	);

	assign pix_in.ready = in_ready;

	`DCMF_ASSERT_NEXT(a_one_item, pix_in.valid && in_ready, !in_ready, "second item taken while busy")
	`DCMF_ASSERT_NOW(a_port_excl, cmd.ram_we, !cmd.ram_re, "line store read and written together")
	`DCMF_ASSERT_NOW(a_emit_free, cmd.emit, !dark_out.valid || dark_out.ready, "result overwritten")
endmodule
`default_nettype wire
